// ===== rtl/core/spfa_pkg.sv =====
// Shared types and codes for the server pool allocator.
`default_nettype none
package spfa_pkg;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// classified command, front to back
	typedef struct packed {
		logic        is_release;
		logic        rel_bad;
		logic [3:0]  rel_index;
		logic [31:0] svc_start;
		logic [31:0] svc_finish;
		logic [31:0] dsvc;
	} cmd_t;

	// per-server statistics entry
	typedef struct packed {
		logic [31:0] last_finish;
		logic [47:0] service_total;
		logic [47:0] idle_total;
		logic [31:0] served_count;
	} stat_t;

	// result item, back to output queue
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  server_index;
		logic [4:0]  idle_count;
		logic        any_idle;
		logic [47:0] service_total;
		logic [47:0] idle_total;
		logic [31:0] served_count;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/core/spfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/spfa_queue.sv =====
// Two-entry queue used between the front, the back and the result ports.
`default_nettype none
module spfa_queue #(
	parameter type item_t = logic
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t wdata,
	output logic       empty,
	input  wire logic  pop,
	output item_t      rdata
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/spfa_front.sv =====
// Front end: accepts input items, classifies them, queues commands.
`default_nettype none
module spfa_front #(
	parameter int SERVERS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        mode,
	input  wire logic [3:0]  release_index,
	input  wire logic [31:0] svc_start,
	input  wire logic [31:0] svc_finish,
	output logic             cmd_valid,
	input  wire logic        cmd_pop,
	output spfa_pkg::cmd_t   cmd
);
	import spfa_pkg::*;

	cmd_t        cls;
	logic        cmd_empty;
	logic [31:0] rel_ext;

	assign rel_ext = 32'(release_index);

	always_comb begin
		cls            = '0;
		cls.is_release = mode;
		cls.rel_bad    = (rel_ext >= 32'(SERVERS));
		cls.rel_index  = release_index;
		cls.svc_start  = svc_start;
		cls.svc_finish = svc_finish;
		// service increment, clamped at zero
		cls.dsvc       = (svc_finish > svc_start) ? (svc_finish - svc_start) : 32'd0;
	end

	spfa_queue #(.item_t(cmd_t)) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (cls),
		.empty (cmd_empty),
		.pop   (cmd_pop),
		.rdata (cmd)
	);

	assign cmd_valid = !cmd_empty;

endmodule
`default_nettype wire

// ===== rtl/core/spfa_back.sv =====
// Back end: idle ring, per-server statistics and result generation.
`default_nettype none
module spfa_back #(
	parameter int SERVERS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_pop,
	input  wire spfa_pkg::cmd_t cmd,
	input  wire logic           res_full,
	output logic                res_push,
	output spfa_pkg::res_t      res
);
	import spfa_pkg::*;

	localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
	localparam int CW = $clog2(SERVERS + 1);
	localparam int SW = $bits(stat_t);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RING = 4'b0010,
		S_STAT = 4'b0100,
		S_ADD  = 4'b1000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [IW-1:0]      head_q;
	logic [IW-1:0]      tail_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_inc;
	logic [SERVERS-1:0] ring_vld_q;
	logic [SERVERS-1:0] stat_vld_q;
	cmd_t               cmd_q;
	logic [IW-1:0]      sidx_q;
	logic [IW-1:0]      sidx_c;
	logic [47:0]        svc_q;
	logic [47:0]        idl_q;
	logic [31:0]        served_q;
	logic [31:0]        didl_q;
	logic [31:0]        didl_c;

	logic               ring_we;
	logic               ring_re;
	logic [IW-1:0]      ring_rdata;
	logic               stat_we;
	logic               stat_re;
	logic [SW-1:0]      stat_rdata;
	stat_t              stat_rd;
	stat_t              stat_cur;
	stat_t              stat_new;
	logic [48:0]        svc_sum;
	logic [48:0]        idl_sum;

	logic               release_ok;

	spfa_ram #(.WIDTH(IW), .DEPTH(SERVERS)) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(tail_q),
		.wdata(IW'(cmd.rel_index)),
		.re   (ring_re),
		.raddr(head_q),
		.rdata(ring_rdata)
	);

	spfa_ram #(.WIDTH(SW), .DEPTH(SERVERS)) u_stat (
		.clk  (clk),
		.we   (stat_we),
		.waddr(sidx_q),
		.wdata(stat_new),
		.re   (stat_re),
		.raddr(sidx_c),
		.rdata(stat_rdata)
	);

	// never-written ring slot i holds index i
	assign sidx_c   = ring_vld_q[head_q] ? ring_rdata : head_q;
	assign stat_rd  = stat_t'(stat_rdata);
	assign stat_cur = stat_vld_q[sidx_q] ? stat_rd : '0;
	assign didl_c   = (cmd_q.svc_start > stat_cur.last_finish)
		? (cmd_q.svc_start - stat_cur.last_finish) : 32'd0;
	assign cnt_inc  = cnt_q + 1'b1;

	assign release_ok = !cmd.rel_bad && (cnt_q != CW'(SERVERS));

	// saturating updates
	assign svc_sum = {1'b0, svc_q} + 49'(cmd_q.dsvc);
	assign idl_sum = {1'b0, idl_q} + 49'(didl_q);

	always_comb begin
		stat_new               = '0;
		stat_new.last_finish   = cmd_q.svc_finish;
		stat_new.service_total = svc_sum[48] ? '1 : svc_sum[47:0];
		stat_new.idle_total    = idl_sum[48] ? '1 : idl_sum[47:0];
		stat_new.served_count  = (served_q == '1) ? served_q : served_q + 32'd1;
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		ring_we  = 1'b0;
		ring_re  = 1'b0;
		stat_re  = 1'b0;
		stat_we  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					if (cmd.is_release) begin
						res_push = 1'b1;
						if (release_ok) begin
							ring_we        = 1'b1;
							res.status     = ST_DONE;
							res.idle_count = 5'(cnt_inc);
							res.any_idle   = 1'b1;
						end else begin
							res.status     = ST_FULL;
							res.idle_count = 5'(cnt_q);
							res.any_idle   = (cnt_q != '0);
						end
					end else if (cnt_q == '0) begin
						res_push   = 1'b1;
						res.status = ST_NONE;
					end else begin
						ring_re = 1'b1;
						state_d = S_RING;
					end
				end
			end
			S_RING: begin
				stat_re = 1'b1;
				state_d = S_STAT;
			end
			S_STAT: begin
				state_d = S_ADD;
			end
			S_ADD: begin
				stat_we           = 1'b1;
				res_push          = 1'b1;
				res.status        = ST_DONE;
				res.server_index  = 4'(sidx_q);
				res.idle_count    = 5'(cnt_q);
				res.any_idle      = (cnt_q != '0);
				res.service_total = stat_new.service_total;
				res.idle_total    = stat_new.idle_total;
				res.served_count  = stat_new.served_count;
				state_d           = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= CW'(SERVERS);
			ring_vld_q <= '0;
			stat_vld_q <= '0;
		end else begin
			state_q <= state_d;
			if (ring_we) begin
				ring_vld_q[tail_q] <= 1'b1;
				tail_q <= (tail_q == IW'(SERVERS - 1)) ? '0 : tail_q + 1'b1;
				cnt_q  <= cnt_inc;
			end
			if (state_q == S_RING) begin
				head_q <= (head_q == IW'(SERVERS - 1)) ? '0 : head_q + 1'b1;
				cnt_q  <= cnt_q - 1'b1;
			end
			if (stat_we) begin
				stat_vld_q[sidx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == S_RING) begin
			sidx_q <= sidx_c;
		end
		if (state_q == S_STAT) begin
			svc_q    <= stat_cur.service_total;
			idl_q    <= stat_cur.idle_total;
			served_q <= stat_cur.served_count;
			didl_q   <= didl_c;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/server_pool_fifo_allocator.sv =====
// Top level of the server pool allocator: front, back and result queue.
//
// Usage: both sides look like queues. An item transfers in on a rising
// edge with push high and full low; mode 0 acquires the oldest idle server,
// mode 1 returns release_index to the idle list. A result transfers out on
// a rising edge with pop high and empty low; the oldest result is on the
// result ports while empty is low.
// Path: a release goes from the command queue through S_IDLE into the
// result queue; an acquire also steps through ring read, stats read, update.
// The back end runs one item at a time: a release or refused acquire is
// finished in S_IDLE, a granted acquire goes through S_RING, S_STAT and
// S_ADD for the two registered RAM reads and the saturating stats update.
// A two-entry command queue keeps the input taking items while the back
// end works; a two-entry result queue lets results wait for pop.
// Reset: all servers idle in order 0..SERVERS-1, all stats zero. This is
// done by per-entry valid flops, so no clearing pass is needed and the
// block takes items right after reset.
// Receiver stall: when the result queue fills, the back end stops, the
// command queue fills, and full rises; nothing is dropped.
`default_nettype none
module server_pool_fifo_allocator #(
	parameter int SERVERS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        mode,
	input  wire logic [3:0]  release_index,
	input  wire logic [31:0] svc_start,
	input  wire logic [31:0] svc_finish,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [3:0]       server_index,
	output logic [4:0]       idle_count,
	output logic             any_idle,
	output logic [47:0]      service_total,
	output logic [47:0]      idle_total,
	output logic [31:0]      served_count
);
	import spfa_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	// front: classify and queue commands
	spfa_front #(.SERVERS(SERVERS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.release_index(release_index),
		.svc_start    (svc_start),
		.svc_finish   (svc_finish),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd)
	);

	// back: idle ring and per-server stats
	spfa_back #(.SERVERS(SERVERS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// results wait here until popped
	spfa_queue #(.item_t(res_t)) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.wdata (res_in),
		.empty (empty),
		.pop   (pop),
		.rdata (res_out)
	);

	assign status        = res_out.status;
	assign server_index  = res_out.server_index;
	assign idle_count    = res_out.idle_count;
	assign any_idle      = res_out.any_idle;
	assign service_total = res_out.service_total;
	assign idle_total    = res_out.idle_total;
	assign served_count  = res_out.served_count;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the server pool allocator: queue-style driver and checking monitor.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spfa_pkg::*;

	// ------------------------------------------------------------------
	// Constants
	// ------------------------------------------------------------------
	localparam int          SERVERS     = 16;
	localparam logic        MODE_ACQUIRE = 1'b0;
	localparam logic        MODE_RELEASE = 1'b1;
	localparam int          RANDOM_ITEMS = 900;
	// Receiver hold-off: starts once this many items went in, lasts this long.
	localparam int unsigned HOLD_AT      = 80;
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned LIMIT_CYCLES = 3_000_000;
	localparam int unsigned MAX_PRINTS   = 40;

	// One input item plus how the driver presents it.
	typedef struct {
		logic        mode;
		logic [3:0]  rel;
		logic [31:0] st;
		logic [31:0] fin;
		int unsigned gap;    // idle cycles before push rises
		bit          drain;  // hold push until every result is back
	} job_t;

	// ------------------------------------------------------------------
	// Clock, reset, DUT
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        mode = 1'b0;
	logic [3:0]  release_index = '0;
	logic [31:0] svc_start = '0;
	logic [31:0] svc_finish = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  status;
	logic [3:0]  server_index;
	logic [4:0]  idle_count;
	logic        any_idle;
	logic [47:0] service_total;
	logic [47:0] idle_total;
	logic [31:0] served_count;

	always #5 clk = ~clk;

	server_pool_fifo_allocator #(
		.SERVERS(SERVERS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.release_index(release_index),
		.svc_start    (svc_start),
		.svc_finish   (svc_finish),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.server_index (server_index),
		.idle_count   (idle_count),
		.any_idle     (any_idle),
		.service_total(service_total),
		.idle_total   (idle_total),
		.served_count (served_count)
	);

	// ------------------------------------------------------------------
	// Pool model: free-list ring plus per-server stats.
	// Updated by the driver at each input transfer; its output goes to
	// the back of pending_results, in transfer order.
	// ------------------------------------------------------------------
	logic [3:0]  free_ring [SERVERS];
	logic [3:0]  free_head;
	logic [3:0]  free_tail;
	logic [4:0]  free_cnt;
	logic [31:0] srv_last_fin [SERVERS];
	logic [47:0] srv_service [SERVERS];
	logic [47:0] srv_idle [SERVERS];
	logic [31:0] srv_grants [SERVERS];

	res_t pending_results[$];

	function automatic void pool_clear();
		for (int i = 0; i < SERVERS; i++) begin
			free_ring[i]    = 4'(i);
			srv_last_fin[i] = '0;
			srv_service[i]  = '0;
			srv_idle[i]     = '0;
			srv_grants[i]   = '0;
		end
		free_head = '0;
		free_tail = '0;
		free_cnt  = 5'(SERVERS);
	endfunction

	// 48-bit accumulate, pinned at all ones on carry out
	function automatic logic [47:0] add_sat48(input logic [47:0] acc, input logic [31:0] inc);
		logic [48:0] sum;
		sum = {1'b0, acc} + {17'b0, inc};
		return sum[48] ? '1 : sum[47:0];
	endfunction

	function automatic res_t pool_apply(input job_t j);
		res_t        r;
		logic [3:0]  s;
		logic [31:0] d_service;
		logic [31:0] d_idle;
		r        = '0;
		r.status = ST_DONE;
		if (j.mode == MODE_ACQUIRE) begin
			if (free_cnt == 0) begin
				r.status = ST_NONE;
			end else begin
				s         = free_ring[free_head];
				// both deltas clamp at zero when the times run backwards
				d_service = (j.fin > j.st) ? j.fin - j.st : '0;
				d_idle    = (j.st > srv_last_fin[s]) ? j.st - srv_last_fin[s] : '0;
				free_head = free_head + 4'd1;
				free_cnt  = free_cnt - 5'd1;
				srv_service[s]  = add_sat48(srv_service[s], d_service);
				srv_idle[s]     = add_sat48(srv_idle[s], d_idle);
				srv_last_fin[s] = j.fin;
				if (srv_grants[s] != '1) begin
					srv_grants[s] = srv_grants[s] + 32'd1;
				end
				r.server_index  = s;
				r.service_total = srv_service[s];
				r.idle_total    = srv_idle[s];
				r.served_count  = srv_grants[s];
			end
		end else begin
			// a 4-bit index is always below SERVERS, so only a full ring refuses
			if (free_cnt == 5'(SERVERS)) begin
				r.status = ST_FULL;
			end else begin
				free_ring[free_tail] = j.rel;
				free_tail = free_tail + 4'd1;
				free_cnt  = free_cnt + 5'd1;
			end
		end
		r.idle_count = free_cnt;
		r.any_idle   = (free_cnt != 0);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building. A light shadow of the idle list lets the
	// generator aim releases at busy servers and drain or refill the pool.
	// ------------------------------------------------------------------
	job_t        jobs[$];
	int          shadow_idle[$];
	int          shadow_busy[$];
	bit          pause_next = 1'b0;
	int unsigned calm_left = 0;
	logic [31:0] tick_now = '0;

	function automatic int unsigned draw_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 40);
		end
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [31:0] pick_tick();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic void add_job(input logic m, input logic [3:0] idx,
			input logic [31:0] st, input logic [31:0] fin);
		job_t j;
		j.mode  = m;
		j.rel   = idx;
		j.st    = st;
		j.fin   = fin;
		j.gap   = draw_gap();
		j.drain = pause_next;
		pause_next = 1'b0;
		jobs.push_back(j);
	endfunction

	function automatic void queue_acquire(input logic [31:0] st, input logic [31:0] fin);
		if (shadow_idle.size() != 0) begin
			shadow_busy.push_back(shadow_idle.pop_front());
		end
		add_job(MODE_ACQUIRE, 4'($urandom()), st, fin);
	endfunction

	function automatic void queue_release(input logic [3:0] idx);
		int k;
		k = -1;
		if (shadow_idle.size() < SERVERS) begin
			shadow_idle.push_back(idx);
			foreach (shadow_busy[i]) begin
				if (k < 0 && shadow_busy[i] == idx) begin
					k = i;
				end
			end
			if (k >= 0) begin
				shadow_busy.delete(k);
			end
		end
		// times are don't-care on release; keep them noisy
		add_job(MODE_RELEASE, idx, $urandom(), $urandom());
	endfunction

	// Acquire on a loosely advancing time line: mostly forward, sometimes
	// finishing before its start, sometimes jumping anywhere.
	function automatic void queue_timed_acquire();
		logic [31:0] st;
		logic [31:0] fin;
		st = tick_now + $urandom_range(0, 40);
		if ($urandom_range(0, 9) == 0) begin
			fin = st - $urandom_range(1, 50);
		end else begin
			fin = st + $urandom_range(0, 300);
		end
		tick_now = ($urandom_range(0, 49) == 0) ? pick_tick() : st + $urandom_range(0, 60);
		queue_acquire(st, fin);
	endfunction

	function automatic void queue_busy_release();
		if (shadow_busy.size() != 0) begin
			queue_release(4'(shadow_busy[$urandom_range(0, shadow_busy.size() - 1)]));
		end else begin
			queue_release(4'($urandom()));
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents one job at a time, honoring its gap and pause.
	// ------------------------------------------------------------------
	job_t        cur;
	bit          loaded = 1'b0;
	int unsigned wait_left = 0;
	int unsigned sent_cnt = 0;
	int unsigned done_cnt = 0;
	bit          in_took;
	bit          in_go;

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			in_took = push && !full;
			in_go   = 1'b0;
			if (in_took) begin
				pending_results.push_back(pool_apply(cur));
				sent_cnt <= sent_cnt + 1;
				loaded = 1'b0;
			end
			if (!loaded && jobs.size() != 0) begin
				cur       = jobs.pop_front();
				loaded    = 1'b1;
				wait_left = cur.gap;
				mode          <= cur.mode;
				release_index <= cur.rel;
				svc_start     <= cur.st;
				svc_finish    <= cur.fin;
			end
			if (push && !in_took) begin
				in_go = 1'b1;   // stalled by full: keep offering
			end else if (loaded && wait_left > 0) begin
				wait_left--;
			end else if (loaded) begin
				// a pausing job does not go in the cycle of a transfer, so sent_cnt is current
				in_go = !cur.drain || (!in_took && sent_cnt == done_cnt);
			end
			push <= in_go;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: pops with random waits, one long hold-off, and checks every
	// transfer out against the oldest pending result.
	// ------------------------------------------------------------------
	int unsigned errors = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_calm = 0;
	bit          held = 1'b0;
	bit          out_took;

	function automatic void report(input string field, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		if (errors <= MAX_PRINTS) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		end
	endfunction

	function automatic void check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= MAX_PRINTS) begin
				$display("%0t: unexpected result, expected none actual status %0h index %0h",
					$time, status, server_index);
			end
			return;
		end
		want = pending_results.pop_front();
		if (status !== want.status)               report("status", want.status, status);
		if (server_index !== want.server_index)   report("server_index", want.server_index,
			server_index);
		if (idle_count !== want.idle_count)       report("idle_count", want.idle_count,
			idle_count);
		if (any_idle !== want.any_idle)           report("any_idle", want.any_idle, any_idle);
		if (service_total !== want.service_total) report("service_total", want.service_total,
			service_total);
		if (idle_total !== want.idle_total)       report("idle_total", want.idle_total,
			idle_total);
		if (served_count !== want.served_count)   report("served_count", want.served_count,
			served_count);
	endfunction

	function automatic int unsigned draw_rx_wait();
		if (rx_calm > 0) begin
			rx_calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			rx_calm = $urandom_range(10, 40);
		end
		return $urandom_range(0, 3);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			out_took = pop && !empty;
			if (out_took) begin
				check_result();
				done_cnt <= done_cnt + 1;
				rx_wait = draw_rx_wait();
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			// one long hold-off so results back up and full rises
			if (!held && sent_cnt >= HOLD_AT) begin
				held    = 1'b1;
				rx_wait = HOLD_CYCLES;
			end
			pop <= (rx_wait == 0);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	int unsigned cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence: build all jobs up front, release reset, wait for the
	// last transfer out, then judge.
	// ------------------------------------------------------------------
	initial begin
		int unsigned random_end;
		int unsigned k;
		int          pick;

		pool_clear();
		for (int i = 0; i < SERVERS; i++) begin
			shadow_idle.push_back(i);
		end

		// --- directed ---
		// pool starts full: releases are refused
		queue_release(4'd0);
		queue_release(4'd15);
		// widest service span, then finish before start with widest idle gap
		queue_acquire(32'h0000_0000, 32'hFFFF_FFFF);
		queue_acquire(32'hFFFF_FFFF, 32'h0000_0000);
		queue_acquire(32'd100, 32'd100);
		queue_acquire(32'd5, 32'd3);
		queue_acquire(32'hAAAA_AAAA, 32'h5555_5555);
		queue_acquire(32'h5555_5555, 32'hAAAA_AAAA);
		queue_release(4'd1);
		queue_release(4'd0);
		// server 9 is still idle: duplicate goes in unchecked
		queue_release(4'd9);
		queue_release(4'd2);
		queue_release(4'd3);
		queue_release(4'd4);
		// ring is full again, so this one is refused
		queue_release(4'd5);
		// server 0 comes back with a start before its last finish later on
		pause_next = 1'b1;
		queue_acquire(32'd7, 32'd1000);

		// --- random ---
		random_end = jobs.size() + RANDOM_ITEMS;
		k = jobs.size() + 150;
		while (jobs.size() < random_end) begin
			if (jobs.size() >= k) begin
				pause_next = 1'b1;
				k += 150;
			end
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				// drain the pool, sometimes one past empty
				repeat (shadow_idle.size() + $urandom_range(0, 1)) queue_timed_acquire();
			end else if (pick < 6) begin
				// hand busy servers back, sometimes one more than fits
				repeat (shadow_busy.size()) queue_busy_release();
				if ($urandom_range(0, 1) == 0) begin
					queue_release(4'($urandom()));
				end
			end else if (pick < 9) begin
				repeat ($urandom_range(2, 12)) begin
					if ($urandom_range(0, 1) == 0) begin
						queue_timed_acquire();
					end else begin
						queue_busy_release();
					end
				end
			end else begin
				// noise: any mode, any index, any times
				repeat ($urandom_range(1, 5)) begin
					if ($urandom_range(0, 1) == 0) begin
						queue_acquire(pick_tick(), pick_tick());
					end else begin
						queue_release(4'($urandom()));
					end
				end
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (jobs.size() != 0 || loaded || push || sent_cnt != done_cnt);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
